FILE: rtl/clw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clw_pkg: shared types and constants of the character display nibble writer
// Holds the request codes, the queued command record, the power-up and clear
// script, and the small helpers for decimal digit extraction.
// ----------------------------------------------------------------------------
package clw_pkg;

  localparam logic [2:0] OP_TICK   = 3'd0;
  localparam logic [2:0] OP_CMD    = 3'd1;
  localparam logic [2:0] OP_DATA   = 3'd2;
  localparam logic [2:0] OP_NUMBER = 3'd3;
  localparam logic [2:0] OP_INIT   = 3'd4;
  localparam logic [2:0] OP_CLEAR  = 3'd5;

  localparam logic [7:0] ASCII_ZERO = 8'h30;

  localparam logic [3:0] SCRIPT_INIT_FIRST  = 4'd1;
  localparam logic [3:0] SCRIPT_INIT_LAST   = 4'd13;
  localparam logic [3:0] SCRIPT_CLEAR_FIRST = 4'd14;
  localparam logic [3:0] SCRIPT_CLEAR_LAST  = 4'd15;

  // One classified request as it waits for the back end.
  typedef struct packed {
    logic [2:0]       opcode;
    logic [7:0]       byte_value;
    logic [3:0][3:0]  digits;    // digits[0] is the units digit
    logic [1:0]       top_idx;   // index of the leading shown digit
  } cmd_t;

  typedef struct packed {
    logic       is_pause;
    logic [7:0] value;
  } script_t;

  // Power-up and clear script. The first pause of the power-up sequence
  // takes its length from the caller.
  function automatic script_t script_lookup(input logic [3:0] s, input logic [5:0] pwait);
    script_t e;
    e = '{is_pause: 1'b0, value: 8'h00};
    unique case (s)
      4'd1:    e = '{is_pause: 1'b1, value: {2'b00, pwait}};
      4'd2:    e.value = 8'h22;
      4'd3:    e.value = 8'h02;
      4'd4:    e.value = 8'h08;
      4'd5:    e = '{is_pause: 1'b1, value: 8'd1};
      4'd7:    e.value = 8'h0C;
      4'd8:    e = '{is_pause: 1'b1, value: 8'd1};
      4'd10:   e.value = 8'h01;
      4'd11:   e = '{is_pause: 1'b1, value: 8'd3};
      4'd13:   e.value = 8'h06;
      4'd14:   e.value = 8'h01;
      4'd15:   e.value = 8'h80;
      default: e.value = 8'h00;
    endcase
    return e;
  endfunction

  function automatic logic [3:0] script_next(input logic [3:0] s);
    if (s == SCRIPT_INIT_LAST || s == SCRIPT_CLEAR_LAST || s == 4'd0) begin
      return 4'd0;
    end
    return s + 4'd1;
  endfunction

  // Quotient digit of v by a constant place value, found with nine
  // independent compares. Callers keep the quotient below ten.
  function automatic logic [3:0] dec_quot(input logic [15:0] v, input logic [15:0] unit);
    logic [3:0] q;
    q = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      if ({1'b0, v} >= 17'(k) * {1'b0, unit}) begin
        q = 4'(k);
      end
    end
    return q;
  endfunction

endpackage

FILE: rtl/clw_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clw_front: request intake and decimal split
// Five-stage pipeline that takes items and peels off one decimal place per
// stage, so a number request reaches the queue with all four digits ready.
// ----------------------------------------------------------------------------
module clw_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [2:0]       opcode,
  input  logic [7:0]       byte_value,
  input  logic [15:0]      number,
  input  logic             q_full,
  output logic             push,
  output clw_pkg::cmd_t    push_cmd
);

  logic        v1, v2, v3, v4, v5;
  logic [2:0]  op1, op2, op3, op4, op5;
  logic [7:0]  bv1, bv2, bv3, bv4, bv5;
  logic [1:0]  top2, top3, top4, top5;
  logic [15:0] num1;
  logic [13:0] r2;
  logic [9:0]  r3;
  logic [6:0]  r4;
  logic [3:0]  d3_3, d3_4, d3_5, d2_4, d2_5, d1_5, d0_5;
  logic        adv;

  logic [3:0]  q_tt, q_th, q_hu, q_te;
  logic [15:0] r_tt, r_th, r_hu, r_te;

  assign adv      = !v5 || !q_full;
  assign in_ready = adv;
  assign push     = v5 && adv;

  assign q_tt = clw_pkg::dec_quot(num1, 16'd10000);
  assign r_tt = num1 - 16'(q_tt * 16'd10000);
  assign q_th = clw_pkg::dec_quot({2'b00, r2}, 16'd1000);
  assign r_th = {2'b00, r2} - 16'(q_th * 16'd1000);
  assign q_hu = clw_pkg::dec_quot({6'd0, r3}, 16'd100);
  assign r_hu = {6'd0, r3} - 16'(q_hu * 16'd100);
  assign q_te = clw_pkg::dec_quot({9'd0, r4}, 16'd10);
  assign r_te = {9'd0, r4} - 16'(q_te * 16'd10);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
    if (adv) begin
      op1  <= opcode;
      bv1  <= byte_value;
      num1 <= number;

      op2  <= op1;
      bv2  <= bv1;
      r2   <= r_tt[13:0];
      top2 <= (num1 >= 16'd1000) ? 2'd3 :
              (num1 >= 16'd100)  ? 2'd2 :
              (num1 >= 16'd10)   ? 2'd1 : 2'd0;

      op3  <= op2;
      bv3  <= bv2;
      top3 <= top2;
      d3_3 <= q_th;
      r3   <= r_th[9:0];

      op4  <= op3;
      bv4  <= bv3;
      top4 <= top3;
      d3_4 <= d3_3;
      d2_4 <= q_hu;
      r4   <= r_hu[6:0];

      op5  <= op4;
      bv5  <= bv4;
      top5 <= top4;
      d3_5 <= d3_4;
      d2_5 <= d2_4;
      d1_5 <= q_te;
      d0_5 <= r_te[3:0];
    end
  end

  always_comb begin
    push_cmd.opcode     = op5;
    push_cmd.byte_value = bv5;
    push_cmd.digits     = {d3_5, d2_5, d1_5, d0_5};
    push_cmd.top_idx    = top5;
  end

endmodule

FILE: rtl/clw_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clw_queue: command queue
// Four-entry queue between the intake pipeline and the pin sequencer.
// ----------------------------------------------------------------------------
module clw_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  clw_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output clw_pkg::cmd_t head
);

  clw_pkg::cmd_t mem [4];
  logic [1:0]    wr_ptr;
  logic [1:0]    rd_ptr;
  logic [2:0]    count;

  assign full      = (count == 3'd4);
  assign not_empty = (count != 3'd0);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 2'd1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      if (push && !pop) begin
        count <= count + 3'd1;
      end else if (pop && !push) begin
        count <= count - 3'd1;
      end
    end
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> not_empty)
    else $error("queue read while empty");
`endif

endmodule

FILE: rtl/clw_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clw_back: pin sequencer
// Carries out one queued item per cycle unless stalled: advances the nibble timing
// on a tick or starts a byte, digit string or script, and registers the pin levels.
// ----------------------------------------------------------------------------
module clw_back #(
  parameter int POWER_UP_WAIT   = 50,
  parameter int ENABLE_LOW_WAIT = 5
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          not_empty,
  input  clw_pkg::cmd_t head,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_data
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_HI_EN, PH_HI_LOW, PH_LO_EN, PH_LO_LOW, PH_TAIL, PH_PAUSE
  } phase_t;

  localparam logic [5:0] LOW_WAIT = 6'(ENABLE_LOW_WAIT);
  localparam logic [5:0] PWR_WAIT = 6'(POWER_UP_WAIT);

  phase_t          phase, phase_next;
  logic [5:0]      wait_ticks, wait_next;
  logic [7:0]      current_byte, byte_next;
  logic            rs_level, rs_next;
  logic [3:0]      sequence_step, seq_next;
  logic [1:0]      digits_left, dl_next;
  logic            enable, enable_next;
  logic [3:0]      nibble, nibble_next;
  logic [3:0]      digit_store [4];
  logic            drop;
  logic            store_we;

  logic            start;
  logic            start_rs;
  logic [7:0]      start_b;
  logic            entry_go;
  logic [3:0]      entry_s;
  logic [3:0]      ns;
  logic [5:0]      wt;
  logic [1:0]      dl_m1;
  clw_pkg::script_t ent;

  assign pop   = not_empty && (!out_valid || out_ready);
  assign dl_m1 = digits_left - 2'd1;

  always_comb begin
    phase_next  = phase;
    wait_next   = wait_ticks;
    byte_next   = current_byte;
    rs_next     = rs_level;
    seq_next    = sequence_step;
    dl_next     = digits_left;
    enable_next = enable;
    nibble_next = nibble;
    drop        = 1'b0;
    store_we    = 1'b0;
    start       = 1'b0;
    start_rs    = 1'b0;
    start_b     = 8'h00;
    entry_go    = 1'b0;
    entry_s     = 4'd0;
    ns          = 4'd0;
    wt          = 6'd0;
    ent         = '{is_pause: 1'b0, value: 8'h00};

    if (pop) begin
      if (head.opcode == clw_pkg::OP_TICK) begin
        if (phase != PH_IDLE) begin
          wt        = (wait_ticks != 6'd0) ? wait_ticks - 6'd1 : 6'd0;
          wait_next = wt;
          if (wt == 6'd0) begin
            unique case (phase)
              PH_HI_EN: begin
                enable_next = 1'b0;
                nibble_next = current_byte[7:4];
                phase_next  = PH_HI_LOW;
                wait_next   = LOW_WAIT;
              end
              PH_HI_LOW: begin
                enable_next = 1'b1;
                nibble_next = current_byte[3:0];
                phase_next  = PH_LO_EN;
                wait_next   = 6'd1;
              end
              PH_LO_EN: begin
                enable_next = 1'b0;
                nibble_next = current_byte[3:0];
                phase_next  = PH_LO_LOW;
                wait_next   = LOW_WAIT;
              end
              PH_LO_LOW: begin
                phase_next = PH_TAIL;
                wait_next  = 6'd1;
              end
              default: begin
                // End of a byte or a pause: next digit, next script entry, or done.
                if (digits_left != 2'd0) begin
                  dl_next  = dl_m1;
                  start    = 1'b1;
                  start_rs = 1'b1;
                  start_b  = {4'd0, digit_store[dl_m1]} + clw_pkg::ASCII_ZERO;
                end else if (sequence_step != 4'd0) begin
                  ns       = clw_pkg::script_next(sequence_step);
                  seq_next = ns;
                  if (ns != 4'd0) begin
                    entry_go = 1'b1;
                    entry_s  = ns;
                  end else begin
                    phase_next = PH_IDLE;
                  end
                end else begin
                  phase_next = PH_IDLE;
                end
              end
            endcase
          end
        end
      end else if (head.opcode <= clw_pkg::OP_CLEAR) begin
        if (phase != PH_IDLE) begin
          drop = 1'b1;
        end else begin
          seq_next = 4'd0;
          dl_next  = 2'd0;
          unique case (head.opcode)
            clw_pkg::OP_CMD: begin
              start   = 1'b1;
              start_b = head.byte_value;
            end
            clw_pkg::OP_DATA: begin
              start    = 1'b1;
              start_rs = 1'b1;
              start_b  = head.byte_value;
            end
            clw_pkg::OP_NUMBER: begin
              store_we = 1'b1;
              dl_next  = head.top_idx;
              start    = 1'b1;
              start_rs = 1'b1;
              start_b  = {4'd0, head.digits[head.top_idx]} + clw_pkg::ASCII_ZERO;
            end
            clw_pkg::OP_INIT: begin
              seq_next = clw_pkg::SCRIPT_INIT_FIRST;
              entry_go = 1'b1;
              entry_s  = clw_pkg::SCRIPT_INIT_FIRST;
            end
            clw_pkg::OP_CLEAR: begin
              seq_next = clw_pkg::SCRIPT_CLEAR_FIRST;
              entry_go = 1'b1;
              entry_s  = clw_pkg::SCRIPT_CLEAR_FIRST;
            end
            default: begin
            end
          endcase
        end
      end
    end

    if (entry_go) begin
      ent = clw_pkg::script_lookup(entry_s, PWR_WAIT);
      if (ent.is_pause) begin
        enable_next = 1'b0;
        phase_next  = PH_PAUSE;
        wait_next   = ent.value[5:0];
      end else begin
        start    = 1'b1;
        start_rs = 1'b0;
        start_b  = ent.value;
      end
    end

    if (start) begin
      rs_next     = start_rs;
      byte_next   = start_b;
      enable_next = 1'b1;
      nibble_next = start_b[7:4];
      phase_next  = PH_HI_EN;
      wait_next   = 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      wait_ticks    <= 6'd0;
      current_byte  <= 8'h00;
      rs_level      <= 1'b0;
      sequence_step <= 4'd0;
      digits_left   <= 2'd0;
      enable        <= 1'b0;
      nibble        <= 4'd0;
      out_valid     <= 1'b0;
    end else begin
      if (pop) begin
        phase         <= phase_next;
        wait_ticks    <= wait_next;
        current_byte  <= byte_next;
        rs_level      <= rs_next;
        sequence_step <= seq_next;
        digits_left   <= dl_next;
        enable        <= enable_next;
        nibble        <= nibble_next;
        out_valid     <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (pop) begin
      out_data <= {drop, (phase_next != PH_IDLE), nibble_next, enable_next, rs_next};
    end
    if (store_we) begin
      for (int i = 0; i < 4; i++) begin
        digit_store[i] <= head.digits[i];
      end
    end
  end

`ifndef SYNTHESIS
  a_enable_phase: assert property (@(posedge clk) disable iff (rst)
    enable |-> (phase == PH_HI_EN || phase == PH_LO_EN))
    else $error("enable high outside an enable phase");
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDLE) |-> (digits_left == 2'd0 && sequence_step == 4'd0))
    else $error("idle with work still pending");
  a_wait_armed: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_IDLE) |-> (wait_ticks != 6'd0))
    else $error("active phase with no wait armed");
  a_drop_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data[7]) |-> out_data[6])
    else $error("request dropped while reported idle");
`endif

endmodule

FILE: rtl/char_lcd_nibble_writer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_nibble_writer_unit: character display writer for a 4-bit bus
// Turns ticks and write requests into RS, enable and data pin levels.
// ----------------------------------------------------------------------------
// The unit takes one item per clock while m_tready takes each result, and
// returns exactly one result item per item, in order. Each item is either a
// 1 ms tick or a request: a command byte, a data byte, a number shown as one
// to four ASCII digits (values above 9999 keep their four low digits), the
// power-up sequence, or clear-then-home. The result carries the pin levels
// after the item, whether a transfer is still running, and whether the item
// was a request that was dropped because one was. Time moves only on ticks:
// each nibble holds enable high for one tick and low for ENABLE_LOW_WAIT
// ticks, and one idle tick follows each byte. The sustained rate is one item
// per cycle while m_tready is high; a full queue stalls the intake. An
// accepted item passes through the intake pipeline, which splits a number
// into decimal digits one place per stage, then the four-entry command
// queue, then the pin sequencer, which updates its state and the output
// register in the same cycle. The queue and the output register let the
// input keep flowing while a result waits to be taken.
// ----------------------------------------------------------------------------
module char_lcd_nibble_writer_unit #(
  parameter int POWER_UP_WAIT   = 50,
  parameter int ENABLE_LOW_WAIT = 5
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [7:0] byte_value, [23:8] number
  input  logic [2:0]  s_tuser,   // [2:0] opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata    // [0] register_select, [1] enable_pin,
                                 // [5:2] bus_nibble, [6] busy_res, [7] dropped
);

  logic          q_push;
  logic          q_full;
  logic          q_pop;
  logic          q_not_empty;
  clw_pkg::cmd_t q_in;
  clw_pkg::cmd_t q_head;

  // Intake: classify items and split numbers into digits.
  clw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .opcode     (s_tuser),
    .byte_value (s_tdata[7:0]),
    .number     (s_tdata[23:8]),
    .q_full     (q_full),
    .push       (q_push),
    .push_cmd   (q_in)
  );

  // Short queue so intake and sequencer stall independently.
  clw_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_cmd  (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  // Sequencer: pin timing, digit strings and the init and clear scripts.
  clw_back #(
    .POWER_UP_WAIT   (POWER_UP_WAIT),
    .ENABLE_LOW_WAIT (ENABLE_LOW_WAIT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .not_empty (q_not_empty),
    .head      (q_head),
    .pop       (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule
